@@ rtl/lkc_pkg.sv @@
// shared types and constants of the lru key-value cache
package lkc_pkg;

  // fixed field widths
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 5;

  // stream packing widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (1 + DATA_W + 1 + KEY_W);

  // default and reset values
  localparam int unsigned          DEFAULT_MAX_ENTRIES = 16;
  localparam logic [CFG_W-1:0]     CAPACITY_RESET      = 5'd16;
  localparam logic signed [DATA_W-1:0] MISS_VALUE      = -32'sd1;

  // operation codes
  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } lkc_kind_e;

  // one request
  typedef struct packed {
    lkc_kind_e                 kind;
    logic signed [KEY_W-1:0]   key;
    logic signed [DATA_W-1:0]  value;
  } lkc_req_t;

  // one result
  typedef struct packed {
    logic                      found;
    logic signed [DATA_W-1:0]  read_value;
    logic                      evicted;
    logic signed [KEY_W-1:0]   evicted_key;
  } lkc_result_t;

endpackage

@@ rtl/lkc_store.sv @@
// entry store with parallel tag match, recency ranks and replacement
module lkc_store #(
  parameter int unsigned MaxEntries = lkc_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  lkc_pkg::lkc_req_t        req_i,
  input  logic [lkc_pkg::CFG_W-1:0] capacity_i,
  output lkc_pkg::lkc_result_t     result_o
);
  import lkc_pkg::*;

  localparam int unsigned RankW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned OccW  = $clog2(MaxEntries + 1);

  // entry state
  logic [MaxEntries-1:0]         valid_q;
  logic [RankW-1:0]              rank_q [MaxEntries];
  logic signed [KEY_W-1:0]       key_q  [MaxEntries];
  logic signed [DATA_W-1:0]      data_q [MaxEntries];
  logic [OccW-1:0]               occ_q;

  // decision signals
  logic [OccW-1:0]               cap_eff;
  logic [OccW-1:0]               oldest;
  logic                          full;
  logic                          hit_any, free_any, old_any;
  logic [MaxEntries-1:0]         hit_oh, free_oh, old_oh;
  logic [RankW-1:0]              hit_rank;
  logic signed [DATA_W-1:0]      hit_data;
  logic signed [KEY_W-1:0]       old_key;
  logic                          age_en;
  logic [OccW-1:0]               age_lim;
  logic [MaxEntries-1:0]         ins_oh, wr_oh, mru_oh;
  logic                          occ_inc;
  lkc_result_t                   res;

  // clamp the configured capacity to 1..MaxEntries
  always_comb begin
    if (32'(capacity_i) == 0) begin
      cap_eff = OccW'(1);
    end else if (32'(capacity_i) > MaxEntries) begin
      cap_eff = OccW'(MaxEntries);
    end else begin
      cap_eff = OccW'(capacity_i);
    end
  end

  assign oldest = occ_q - OccW'(1);
  assign full   = (occ_q >= cap_eff) && (occ_q != '0);

  // parallel tag compare, free slot search and oldest entry search
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    old_any  = 1'b0;
    hit_oh   = '0;
    free_oh  = '0;
    old_oh   = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (valid_q[i] && key_q[i] == req_i.key && !hit_any) begin
        hit_oh[i] = 1'b1;
        hit_any   = 1'b1;
      end
      if (!valid_q[i] && !free_any) begin
        free_oh[i] = 1'b1;
        free_any   = 1'b1;
      end
      if (valid_q[i] && OccW'(rank_q[i]) == oldest && !old_any) begin
        old_oh[i] = 1'b1;
        old_any   = 1'b1;
      end
    end
  end

  // read out the selected entries
  always_comb begin
    hit_rank = '0;
    hit_data = '0;
    old_key  = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (hit_oh[i]) begin
        hit_rank = hit_rank | rank_q[i];
        hit_data = hit_data | data_q[i];
      end
      if (old_oh[i]) begin
        old_key = old_key | key_q[i];
      end
    end
  end

  // operation decision and result
  always_comb begin
    res         = '0;
    age_en      = 1'b0;
    age_lim     = '0;
    ins_oh      = '0;
    wr_oh       = '0;
    occ_inc     = 1'b0;
    if (hit_any) begin
      res.found = 1'b1;
      age_en    = 1'b1;
      age_lim   = OccW'(hit_rank);
      if (req_i.kind == KIND_PUT) begin
        wr_oh = hit_oh;
      end else begin
        res.read_value = hit_data;
      end
    end else if (req_i.kind == KIND_GET) begin
      res.read_value = MISS_VALUE;
    end else if (full) begin
      res.evicted     = 1'b1;
      res.evicted_key = old_key;
      age_en          = 1'b1;
      age_lim         = oldest;
      ins_oh          = old_oh;
    end else begin
      age_en  = 1'b1;
      age_lim = occ_q;
      ins_oh  = free_oh;
      occ_inc = 1'b1;
    end
  end

  assign mru_oh   = hit_oh | ins_oh;
  assign result_o = res;

  // valid bits, ranks and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < MaxEntries; i++) begin
        rank_q[i] <= '0;
      end
    end else if (step_i) begin
      for (int i = 0; i < MaxEntries; i++) begin
        if (mru_oh[i]) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && age_en && OccW'(rank_q[i]) < age_lim) begin
          rank_q[i] <= rank_q[i] + RankW'(1);
        end
        if (ins_oh[i]) begin
          valid_q[i] <= 1'b1;
        end
      end
      if (occ_inc) begin
        occ_q <= occ_q + OccW'(1);
      end
    end
  end

  // keys and data, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxEntries; i++) begin
      if (step_i && ins_oh[i]) begin
        key_q[i] <= req_i.key;
      end
      if (step_i && (ins_oh[i] || wr_oh[i])) begin
        data_q[i] <= req_i.value;
      end
    end
  end

  // occupancy tracks the valid bits
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy does not match valid entries");

  // occupancy never exceeds the store
  a_occ_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= MaxEntries)
    else $error("occupancy above store size");

  // at most one hit, and never a hit together with an eviction
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> $onehot0(valid_q & {MaxEntries{1'b1}} & hit_oh) && !(hit_any && res.evicted))
    else $error("hit and eviction together");

  // a put that misses always finds a slot
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !hit_any && req_i.kind == KIND_PUT) |-> $onehot(ins_oh))
    else $error("put miss without a slot");

  // an accepted put never lowers the occupancy unless the store was full
  a_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && req_i.kind == KIND_PUT) |=> $past(occ_q) <= occ_q || $past(full))
    else $error("occupancy dropped after put");

endmodule

@@ rtl/lru_key_value_cache.sv @@
// top level of the lru key-value cache: stream handshake and capacity register
//
// Fully associative key-value cache with least-recently-used replacement.
// Slave stream: s_axis_tuser carries the operation (0 get, 1 put) and
// s_axis_tdata the key and value. Master stream: one result transaction per
// request, with found flag, read value, evicted flag and evicted key.
// Each request is registered in the input register, looked up in the store, and
// its result is registered in the result register before it shows on the master side.
// Throughput: one request per cycle while the receiver takes results; every
// request is handled by a parallel tag compare and rank update over all entries.
// The configuration channel writes the capacity (1..MaxEntries, 0 acts as 1,
// larger values act as MaxEntries); it is always ready. The user must write it
// only while no request is in flight; the block itself does not enforce this.
// Reset empties the cache and sets the capacity to 16.
// When the receiver stalls, the result register holds its transaction and the
// input register holds one more request; s_axis_tready drops once both are full.
module lru_key_value_cache #(
  parameter int unsigned MaxEntries = lkc_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // capacity register write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lkc_pkg::CFG_W-1:0]          cfg_data_i,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lkc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // key[31:0], value[63:32]
  input  logic                               s_axis_tuser,  // kind
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lkc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // found[0], read_value[32:1],
                                                            // evicted[33], evicted_key[65:34]
);
  import lkc_pkg::*;

  logic [CFG_W-1:0] capacity_q;
  logic             in_valid_q;
  lkc_req_t         req_q;
  logic             out_valid_q;
  lkc_result_t      res_q;
  lkc_result_t      result;
  logic             advance;
  logic             step;

  // capacity register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  // handshake control
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q.kind  <= lkc_kind_e'(s_axis_tuser);
      req_q.key   <= s_axis_tdata[KEY_W-1:0];
      req_q.value <= s_axis_tdata[KEY_W+DATA_W-1:KEY_W];
    end
  end

  // entry store
  lkc_store #(
    .MaxEntries (MaxEntries)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .req_i      (req_q),
    .capacity_i (capacity_q),
    .result_o   (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_q.evicted_key, res_q.evicted,
                          res_q.read_value, res_q.found};

endmodule

@@ test/lru_key_value_cache_tb.sv @@
// testbench of the lru key-value cache: directed, random and backpressure tests
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
  import lkc_pkg::*;

  localparam int ENTRIES     = DEFAULT_MAX_ENTRIES;
  localparam int CYCLE_LIMIT = 300000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // key[31:0], value[63:32]
  logic                   s_axis_tuser;   // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // found[0], read_value[32:1],
                                          // evicted[33], evicted_key[65:34]

  // predicted cache contents
  logic                line_valid [ENTRIES];
  logic [KEY_W-1:0]    line_key   [ENTRIES];
  logic [DATA_W-1:0]   line_data  [ENTRIES];
  int                  line_rank  [ENTRIES];
  int                  line_count;
  logic [CFG_W-1:0]    capacity_setting;

  lkc_result_t         awaited_results [$];
  logic [KEY_W-1:0]    key_pool [$];
  int                  fail_count;
  int                  cycle_count;
  int                  src_idle_pct;
  int                  sink_stall_pct;
  int                  sink_hold_left;

  lru_key_value_cache u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // make every valid line with a rank below the limit one step older
  function automatic void age_lines(input int below);
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_rank[i] < below) line_rank[i]++;
    end
  endfunction

  // apply one get or put to the predicted cache and queue its result
  function automatic void lru_access(input lkc_kind_e kind, input logic [KEY_W-1:0] key,
                                     input logic [DATA_W-1:0] value);
    lkc_result_t res;
    int          cap;
    int          hit;
    int          slot;
    res  = '0;
    cap  = capacity_setting;
    hit  = -1;
    slot = -1;
    if (cap == 0) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && line_valid[i] && line_key[i] == key) hit = i;
    end
    if (hit >= 0) begin
      res.found = 1'b1;
      age_lines(line_rank[hit]);
      line_rank[hit] = 0;
      if (kind == KIND_PUT) line_data[hit] = value;
      else res.read_value = line_data[hit];
    end else if (kind == KIND_GET) begin
      res.read_value = MISS_VALUE;
    end else begin
      if (line_count >= cap && line_count > 0) begin
        // full: the least recent line makes room
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && line_valid[i] && line_rank[i] == line_count - 1) slot = i;
        end
        res.evicted     = 1'b1;
        res.evicted_key = line_key[slot];
        age_lines(line_count - 1);
      end else begin
        // room left: lowest free line
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !line_valid[i]) slot = i;
        end
        age_lines(line_count);
        line_count++;
      end
      line_valid[slot] = 1'b1;
      line_key[slot]   = key;
      line_data[slot]  = value;
      line_rank[slot]  = 0;
    end
    awaited_results.push_back(res);
  endfunction

  // receiver: random stalls plus a counted hold-off
  always @(negedge clk_i) begin
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    lkc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tdata[32:1] !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, m_axis_tdata[32:1]);
          fail_count++;
        end
        if (m_axis_tdata[33] !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, m_axis_tdata[33]);
          fail_count++;
        end
        if (m_axis_tdata[65:34] !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, m_axis_tdata[65:34]);
          fail_count++;
        end
      end
    end
  end

  // send one request transaction; entered and left at a falling edge, tvalid left high
  task automatic send_request(input lkc_kind_e kind, input logic [KEY_W-1:0] key,
                              input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, key};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    lru_access(kind, key, value);
    @(negedge clk_i);
  endtask

  // stop sending and wait until every predicted result has arrived
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // capacity write, only with the block idle
  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    wait_for_results();
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity_setting = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // keys mostly come from a small pool so that hits and evictions are common
  task automatic refill_key_pool(input int size);
    key_pool.delete();
    repeat (size) key_pool.push_back($urandom);
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return pick_extreme();
    if (roll < 20) return $urandom;
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  task automatic run_random_items(input int count);
    lkc_kind_e         kind;
    logic [DATA_W-1:0] value;
    repeat (count) begin
      kind  = ($urandom_range(99) < 55) ? KIND_PUT : KIND_GET;
      value = ($urandom_range(9) == 0) ? pick_extreme() : $urandom;
      send_request(kind, pick_key(), value);
    end
  endtask

  // extremes, both operations, capacity lowered below occupancy, zero and oversize capacity
  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_request(KIND_GET, 32'h0000_0000, 32'h1234_5678);
    send_request(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(KIND_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(KIND_GET, 32'hffff_ffff, 32'h0000_0000);
    send_request(KIND_PUT, 32'h0000_0000, 32'h0000_007b);
    send_request(KIND_GET, 32'h0000_0000, 32'hffff_ffff);
    send_request(KIND_GET, 32'h7fff_ffff, 32'h0000_0000);
    // four lines held, capacity lowered to two
    write_capacity(5'd2);
    send_request(KIND_PUT, 32'h0000_0055, 32'h0000_00aa);
    send_request(KIND_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(KIND_PUT, 32'h0000_0066, 32'h0000_00bb);
    send_request(KIND_GET, 32'h0000_0055, 32'h0000_0000);
    // zero acts as one
    write_capacity(5'd0);
    send_request(KIND_PUT, 32'h0000_0077, 32'h0000_00cc);
    send_request(KIND_PUT, 32'h0000_0088, 32'h0000_00dd);
    send_request(KIND_GET, 32'h0000_0077, 32'h0000_0000);
    // above the line count acts as the maximum
    write_capacity(5'd31);
    send_request(KIND_PUT, 32'h0000_0099, 32'h0000_00ee);
    send_request(KIND_GET, 32'h0000_0088, 32'h0000_0000);
    send_request(KIND_GET, 32'h0000_0099, 32'h0000_0000);
    wait_for_results();
  endtask

  // random traffic over the idling phases and a range of capacities
  task automatic test_random_traffic();
    int          src_pct  [4];
    int          sink_pct [4];
    logic [4:0]  caps     [12];
    int          eff;
    src_pct  = '{0, 83, 0, 29};
    sink_pct = '{0, 0, 83, 29};
    caps     = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd7, 5'd3, 5'd16, 5'd2, 5'd12, 5'd1, 5'd9, 5'd5};
    for (int phase = 0; phase < 4; phase++) begin
      for (int chunk = 0; chunk < 3; chunk++) begin
        write_capacity(caps[phase * 3 + chunk]);
        src_idle_pct   = src_pct[phase];
        sink_stall_pct = sink_pct[phase];
        eff = caps[phase * 3 + chunk];
        if (eff == 0) eff = 1;
        if (eff > ENTRIES) eff = ENTRIES;
        refill_key_pool(eff + $urandom_range(1, 8));
        run_random_items(90);
      end
    end
    wait_for_results();
  endtask

  // long receiver hold-off with the sender pushing, then a full drain
  task automatic test_backpressure();
    write_capacity(5'd4);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    refill_key_pool(6);
    @(posedge clk_i);
    sink_hold_left = 300;
    @(negedge clk_i);
    run_random_items(24);
    wait_for_results();
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = KIND_GET;
    m_axis_tready    = 1'b0;
    fail_count       = 0;
    cycle_count      = 0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    sink_hold_left   = 0;
    line_count       = 0;
    capacity_setting = CAPACITY_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_data[i]  = '0;
      line_rank[i]  = 0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_traffic();
    test_backpressure();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
